// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with asynchronous active-low reset disable
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	`ASSERT_PROP(label, clk, rst_n, (cond), msg)

`endif

// ===== rtl/jmfs_pkg.sv =====
// shared types and constants of the mjpeg frame splitter
package jmfs_pkg;

	localparam int COUNT_BITS_DEF    = 25;
	localparam int SEQUENCE_BITS_DEF = 32;
	localparam int LIMIT_W           = 25;
	localparam int NUMBER_W          = 32;
	localparam int QUEUE_DEPTH       = 4;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4 * 1024 * 1024);

	localparam logic [7:0] MARK_FF  = 8'hFF;
	localparam logic [7:0] SOI_CODE = 8'hD8;
	localparam logic [7:0] EOI_CODE = 8'hD9;

	// one result transfer
	typedef struct packed {
		logic [7:0]          out_byte;
		logic                frame_first;
		logic                frame_last;
		logic                frame_abort;
		logic [NUMBER_W-1:0] frame_number;
		logic                run_last;
	} res_t;

	// up to two results produced by one input byte, item0 goes out first
	typedef struct packed {
		logic en0;
		logic en1;
		res_t item0;
		res_t item1;
	} push_t;

endpackage

// ===== rtl/jpeg_marker_frame_splitter.sv =====
// top level of the mjpeg frame splitter
// Cuts whole JPEG images out of a raw MJPEG byte stream. Bytes are dropped
// until a start marker FF D8 is seen; the FF then goes out flagged as
// frame_first, followed by the D8, and every later byte passes through until
// FF D9, whose D9 goes out flagged frame_last with a sequence number counting
// from 1. A frame whose byte count exceeds max_frame_bytes (written on the
// cfg channel, reset 4194304) is ended by one abort transfer with a zero
// payload and the splitter hunts again. Rate: one input byte per clock while
// the result queue has room; each byte is registered in the input stage and
// then passes the marker and length logic into a four-entry result queue,
// whose head drives the master side. A start marker makes two results from
// one byte, and the input stalls whenever the queue holds more than two
// results. tlast marks the last result caused by one input byte; cfg_ready
// is always high.
module jpeg_marker_frame_splitter import jmfs_pkg::*; #(
	parameter int COUNT_BITS    = COUNT_BITS_DEF,
	parameter int SEQUENCE_BITS = SEQUENCE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [LIMIT_W-1:0]        cfg_data,   // max_frame_bytes
	// raw stream in
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,    // data_byte
	// frame bytes out
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [NUMBER_W+7:0]       m_tdata,    // out_byte, frame_number
	output logic [2:0]                m_tuser,    // frame_first, frame_last, frame_abort
	output logic                      m_tlast     // run_last
);

	logic  in_valid_s1;
	logic  [7:0] in_byte_s1;
	logic  room;
	logic  head_valid;
	logic  pop;
	res_t  head;
	push_t push;

	// register may be written any time the splitter is idle
	assign cfg_ready = 1'b1;

	// input stage drains whenever the queue has room for two results
	assign s_tready = !in_valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1 <= s_tdata;
		end
	end

	jmfs_frame_fsm #(
		.COUNT_BITS    (COUNT_BITS),
		.SEQUENCE_BITS (SEQUENCE_BITS)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid_s1 && room),
		.in_byte   (in_byte_s1),
		.push      (push)
	);

	jmfs_out_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.room       (room),
		.head_valid (head_valid),
		.head       (head)
	);

	// head of the queue drives the master side
	assign pop      = head_valid && m_tready;
	assign m_tvalid = head_valid;
	assign m_tdata  = {head.frame_number, head.out_byte};
	assign m_tuser  = {head.frame_abort, head.frame_last, head.frame_first};
	assign m_tlast  = head.run_last;

endmodule

// ===== rtl/jmfs_frame_fsm.sv =====
// marker tracking, length limit and sequence counter
module jmfs_frame_fsm import jmfs_pkg::*; #(
	parameter int COUNT_BITS    = COUNT_BITS_DEF,
	parameter int SEQUENCE_BITS = SEQUENCE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [LIMIT_W-1:0] cfg_data,
	input  logic               in_valid,
	input  logic [7:0]         in_byte,
	output push_t              push
);

	localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
	localparam int NUM_W = (SEQUENCE_BITS < NUMBER_W) ? SEQUENCE_BITS : NUMBER_W;

	logic [LIMIT_W-1:0]       max_q;
	logic                     in_frame_q, in_frame_d;
	logic                     prev_ff_q, prev_ff_d;
	logic [COUNT_BITS-1:0]    cnt_q, cnt_d, cnt_inc;
	logic [SEQUENCE_BITS-1:0] seq_q, seq_d, seq_inc;
	logic                     is_ff;

	assign is_ff   = (in_byte == MARK_FF);
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
	assign seq_inc = seq_q + SEQUENCE_BITS'(1);

	always_comb begin
		in_frame_d = in_frame_q;
		prev_ff_d  = prev_ff_q;
		cnt_d      = cnt_q;
		seq_d      = seq_q;
		push       = '0;
		if (in_valid) begin
			if (!in_frame_q) begin
				if (prev_ff_q && in_byte == SOI_CODE) begin
					in_frame_d                = 1'b1;
					prev_ff_d                 = 1'b0;
					cnt_d                     = COUNT_BITS'(2);
					push.en0                  = 1'b1;
					push.en1                  = 1'b1;
					push.item0.out_byte       = MARK_FF;
					push.item0.frame_first    = 1'b1;
					push.item1.out_byte       = SOI_CODE;
					push.item1.run_last       = 1'b1;
				end else begin
					prev_ff_d = is_ff;
				end
			end else if (prev_ff_q && in_byte == EOI_CODE) begin
				// end marker wins over the length check
				seq_d                    = seq_inc;
				in_frame_d               = 1'b0;
				prev_ff_d                = 1'b0;
				cnt_d                    = '0;
				push.en0                 = 1'b1;
				push.item0.out_byte      = in_byte;
				push.item0.frame_last    = 1'b1;
				push.item0.frame_number  = NUMBER_W'(seq_inc[NUM_W-1:0]);
				push.item0.run_last      = 1'b1;
			end else if (CMP_W'(cnt_inc) > CMP_W'(max_q)) begin
				in_frame_d               = 1'b0;
				prev_ff_d                = 1'b0;
				cnt_d                    = '0;
				push.en0                 = 1'b1;
				push.item0.frame_abort   = 1'b1;
				push.item0.run_last      = 1'b1;
			end else begin
				prev_ff_d                = is_ff;
				cnt_d                    = cnt_inc;
				push.en0                 = 1'b1;
				push.item0.out_byte      = in_byte;
				push.item0.run_last      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q      <= LIMIT_RESET;
			in_frame_q <= 1'b0;
			prev_ff_q  <= 1'b0;
			cnt_q      <= '0;
			seq_q      <= '0;
		end else begin
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
			in_frame_q <= in_frame_d;
			prev_ff_q  <= prev_ff_d;
			cnt_q      <= cnt_d;
			seq_q      <= seq_d;
		end
	end

endmodule

// ===== rtl/jmfs_out_queue.sv =====
// small result queue taking up to two results per cycle
module jmfs_out_queue import jmfs_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output logic  room,
	output logic  head_valid,
	output res_t  head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_nxt;
	logic [CNT_W-1:0] cnt_q;

	assign wr_nxt     = wr_ptr_q + PTR_W'(1);
	assign room       = (cnt_q <= CNT_W'(DEPTH - 2));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.en0) begin
			mem_q[wr_ptr_q] <= push.item0;
		end
		if (push.en1) begin
			mem_q[wr_nxt] <= push.item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.en0) + PTR_W'(push.en1);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push.en0) + CNT_W'(push.en1) - CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/jmfs_checker.sv =====
// port-level checks of the frame splitter and their bind
`include "assert_macros.svh"

module jmfs_checker import jmfs_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [NUMBER_W+7:0] m_tdata,
	input logic [2:0]          m_tuser,
	input logic                m_tlast
);

	logic                 waiting;
	logic [NUMBER_W+12:0] out_word;
	logic                 flags_ok;
	logic                 first_ok;
	logic                 first_done;
	logic                 soi_ok;
	logic                 abort_ok;

	assign waiting    = m_tvalid && !m_tready;
	assign out_word   = {m_tvalid, m_tlast, m_tuser, m_tdata};
	assign flags_ok   = !m_tvalid || $onehot0(m_tuser);
	assign first_ok   = !m_tvalid || !m_tuser[0] || (m_tdata[7:0] == MARK_FF && !m_tlast);
	assign first_done = m_tvalid && m_tready && m_tuser[0];
	assign soi_ok     = m_tvalid && m_tdata[7:0] == SOI_CODE && m_tlast && m_tuser == 3'b000;
	assign abort_ok   = !m_tvalid || !m_tuser[2] || (m_tdata == '0 && m_tlast);

	// stalled result holds
	`ASSERT_PROP(a_out_hold, clk, arst_n, waiting |=> $stable(out_word), "result not held")

	// at most one flag per result
	`ASSERT_ALWAYS(a_flags_onehot, clk, arst_n, flags_ok, "more than one frame flag set")

	// frame start is an FF that is not the last of its run
	`ASSERT_ALWAYS(a_first_ff, clk, arst_n, first_ok, "bad frame start result")

	// the D8 of the start marker follows at once
	`ASSERT_PROP(a_first_then_soi, clk, arst_n, first_done |=> soi_ok, "no D8 after start")

	// abort carries a zero payload and ends its run
	`ASSERT_ALWAYS(a_abort_zero, clk, arst_n, abort_ok, "abort result has payload")

endmodule

bind jpeg_marker_frame_splitter jmfs_checker u_jmfs_checker (.*);
